FILE: rtl/cdq_pkg.sv
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int DEFAULT_DEPTH = 8;
    localparam int OCC_W = 4;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic  fire;
        kind_t op;
    } cmd_t;

endpackage

FILE: rtl/circular_double_ended_queue.sv
// Top level of the double-ended queue built as a chain of shifting storage cells.
// The queue holds up to DEPTH signed 32-bit words, front word always in the first cell.
// Each beat on the input channel carries one operation (push front, push rear, pop front,
// pop rear) and produces exactly one registered result beat, giving the popped word,
// a status (done, rejected because full, rejected because empty) and the occupancy after
// the operation, reported in 4 bits. One operation is taken every cycle: all cells update
// together in the cycle of acceptance, and the single output register stalls the input
// only while a result is held back by out_stall. There is no clearing pass after reset.
module circular_double_ended_queue #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cdq_pkg::DATA_W-1:0] popped_value,
    output logic [1:0]                        status,
    output logic [cdq_pkg::OCC_W-1:0]         occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [cdq_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic signed [cdq_pkg::DATA_W-1:0] cell_tap  [DEPTH];
    logic [DEPTH-1:0]                  cell_occ;
    logic signed [cdq_pkg::DATA_W-1:0] rear_word;

    cdq_pkg::kind_t  op;
    cdq_pkg::cmd_t   cmd;
    cdq_pkg::status_t status_next;
    logic            accept;
    logic            full;
    logic            empty;
    logic            is_push;

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [cdq_pkg::DATA_W-1:0] popped_value_reg;
    logic signed [cdq_pkg::DATA_W-1:0] popped_value_next;
    cdq_pkg::status_t                  status_reg;
    logic [cdq_pkg::OCC_W-1:0]         occupancy_reg;

    assign op       = cdq_pkg::kind_t'(kind);
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = cell_occ[DEPTH-1];
    assign empty    = !cell_occ[0];
    assign is_push  = (op == cdq_pkg::KIND_PUSH_FRONT) || (op == cdq_pkg::KIND_PUSH_REAR);

    always_comb
    begin
        status_next       = cdq_pkg::STATUS_DONE;
        popped_value_next = '0;
        count_next        = count_reg;
        if (is_push)
        begin
            if (full)
            begin
                status_next = cdq_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = cdq_pkg::STATUS_EMPTY;
            end
            else
            begin
                count_next        = count_reg - 1'b1;
                popped_value_next = (op == cdq_pkg::KIND_POP_FRONT) ? cell_data[0] : rear_word;
            end
        end
    end

    assign cmd.fire = accept && (status_next == cdq_pkg::STATUS_DONE);
    assign cmd.op   = op;

    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | cell_tap[i];
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [cdq_pkg::DATA_W-1:0] prev_data;
        logic                              prev_occ;
        logic signed [cdq_pkg::DATA_W-1:0] next_data;
        logic                              next_occ;

        if (i == 0)
        begin : g_first
            assign prev_data = push_value;
            assign prev_occ  = 1'b1;
        end
        else
        begin : g_mid
            assign prev_data = cell_data[i-1];
            assign prev_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_data = '0;
            assign next_occ  = 1'b0;
        end
        else
        begin : g_inner
            assign next_data = cell_data[i+1];
            assign next_occ  = cell_occ[i+1];
        end

        cdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .push_value (push_value),
            .prev_data  (prev_data),
            .prev_occ   (prev_occ),
            .next_data  (next_data),
            .next_occ   (next_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .rear_tap   (cell_tap[i])
        );
    end

    assign out_valid_next = accept ? 1'b1 : in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fire)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_value_reg <= popped_value_next;
            status_reg       <= status_next;
            occupancy_reg    <= cdq_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

endmodule

FILE: rtl/cdq_cell.sv
// One storage cell of the queue's shift chain, holding a word and its occupied flag.
module cdq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cdq_pkg::cmd_t                   cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
    input  logic signed [cdq_pkg::DATA_W-1:0] prev_data,
    input  logic                            prev_occ,
    input  logic signed [cdq_pkg::DATA_W-1:0] next_data,
    input  logic                            next_occ,
    output logic signed [cdq_pkg::DATA_W-1:0] data,
    output logic                            occ,
    output logic signed [cdq_pkg::DATA_W-1:0] rear_tap
);

    logic signed [cdq_pkg::DATA_W-1:0] data_reg;
    logic signed [cdq_pkg::DATA_W-1:0] data_next;
    logic                              occ_reg;
    logic                              occ_next;
    logic                              is_rear;

    assign is_rear = occ_reg && !next_occ;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (cmd.fire)
        begin
            unique case (cmd.op)
                cdq_pkg::KIND_PUSH_FRONT:
                begin
                    data_next = prev_data;
                    occ_next  = prev_occ;
                end
                cdq_pkg::KIND_PUSH_REAR:
                begin
                    if (!occ_reg && prev_occ)
                    begin
                        data_next = push_value;
                        occ_next  = 1'b1;
                    end
                end
                cdq_pkg::KIND_POP_FRONT:
                begin
                    data_next = next_data;
                    occ_next  = next_occ;
                end
                cdq_pkg::KIND_POP_REAR:
                begin
                    if (is_rear)
                    begin
                        occ_next = 1'b0;
                    end
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign occ      = occ_reg;
    assign rear_tap = is_rear ? data_reg : '0;

endmodule

FILE: rtl/cdq_checker.sv
// Port-level checker for the double-ended queue and its bind to the top level.
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [cdq_pkg::DATA_W-1:0] popped_value,
    input logic [1:0]                        status,
    input logic [cdq_pkg::OCC_W-1:0]         occupancy
);

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("Accepted beat produced no result beat.");

    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall == (out_valid && out_stall)))
        else $error("Input stall does not follow a held result.");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(popped_value)
            && $stable(status) && $stable(occupancy)))
        else $error("Held result beat changed.");

    a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != cdq_pkg::STATUS_DONE)) |-> (popped_value == '0))
        else $error("Rejected operation returned a nonzero word.");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == cdq_pkg::STATUS_FULL))
            |-> (occupancy == cdq_pkg::OCC_W'(DEPTH)))
        else $error("Full rejection reported with wrong occupancy.");

endmodule

bind circular_double_ended_queue cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
);

FILE: sim/circular_double_ended_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular double-ended queue with a built-in deque predictor.
module circular_double_ended_queue_test;

    localparam int DEPTH = cdq_pkg::DEFAULT_DEPTH;
    localparam int RANDOM_OPS = 700;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        cdq_pkg::kind_t                    op;
        logic signed [cdq_pkg::DATA_W-1:0] word;
    } deque_op_t;

    typedef struct packed {
        logic signed [cdq_pkg::DATA_W-1:0] word;
        cdq_pkg::status_t                  st;
        logic [cdq_pkg::OCC_W-1:0]         occ;
    } deque_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [1:0]                        kind = cdq_pkg::KIND_PUSH_FRONT;
    logic signed [cdq_pkg::DATA_W-1:0] push_value = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [cdq_pkg::DATA_W-1:0] popped_value;
    logic [1:0]                        status;
    logic [cdq_pkg::OCC_W-1:0]         occupancy;

    deque_op_t     op_backlog[$];
    deque_result_t expected_results[$];

    logic [cdq_pkg::DATA_W-1:0] ring [DEPTH];
    int unsigned                head_pos = 0;
    int unsigned                tail_pos = 0;
    int unsigned                word_count = 0;

    logic in_took;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles = 0;
    int   errors = 0;
    int   ops_accepted = 0;
    int   results_checked = 0;
    int   peak_occ = 0;
    int   status_seen[3] = '{0, 0, 0};

    circular_double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .popped_value(popped_value),
        .status(status),
        .occupancy(occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic deque_result_t deque_apply(cdq_pkg::kind_t op,
                                                  logic [cdq_pkg::DATA_W-1:0] word);
        deque_result_t r;
        r.word = '0;
        r.st = cdq_pkg::STATUS_DONE;
        if (op == cdq_pkg::KIND_PUSH_FRONT || op == cdq_pkg::KIND_PUSH_REAR)
        begin
            if (word_count >= DEPTH)
                r.st = cdq_pkg::STATUS_FULL;
            else
            begin
                // A push into an empty queue always lands in slot zero.
                if (word_count == 0)
                begin
                    head_pos = 0;
                    tail_pos = 0;
                    ring[0] = word;
                end
                else if (op == cdq_pkg::KIND_PUSH_FRONT)
                begin
                    head_pos = (head_pos + DEPTH - 1) % DEPTH;
                    ring[head_pos] = word;
                end
                else
                begin
                    tail_pos = (tail_pos + 1) % DEPTH;
                    ring[tail_pos] = word;
                end
                word_count++;
            end
        end
        else if (word_count == 0)
            r.st = cdq_pkg::STATUS_EMPTY;
        else
        begin
            if (op == cdq_pkg::KIND_POP_FRONT)
            begin
                r.word = ring[head_pos];
                head_pos = (head_pos + 1) % DEPTH;
            end
            else
            begin
                r.word = ring[tail_pos];
                tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
            end
            word_count--;
            if (word_count == 0)
            begin
                head_pos = 0;
                tail_pos = 0;
            end
        end
        r.occ = cdq_pkg::OCC_W'(word_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(deque_apply(cdq_pkg::kind_t'(kind), push_value));
                ops_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat: popped %0d status %0d occupancy %0d",
                             $time, popped_value, status, occupancy);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (popped_value !== want.word)
                    begin
                        errors++;
                        $display("%0t: popped_value expected %0d actual %0d",
                                 $time, want.word, popped_value);
                    end
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (occupancy !== want.occ)
                    begin
                        errors++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, occupancy);
                    end
                    status_seen[want.st]++;
                    if (want.occ > peak_occ)
                        peak_occ = want.occ;
                    results_checked++;
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        deque_op_t next_op;
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_op = op_backlog.pop_front();
                    in_valid <= 1'b1;
                    kind <= next_op.op;
                    push_value <= next_op.word;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    task automatic queue_op(cdq_pkg::kind_t op, logic [cdq_pkg::DATA_W-1:0] word);
        deque_op_t item;
        item.op = op;
        item.word = word;
        op_backlog.push_back(item);
    endtask

    // Bursts lean toward pushes or pops so that the queue swings between full and empty.
    task automatic queue_random_ops(int count);
        int run;
        int push_pct;
        while (count > 0)
        begin
            run = $urandom_range(40, 12);
            case ($urandom_range(2, 0))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            for (int i = 0; i < run && count > 0; i++)
            begin
                if ($urandom_range(99, 0) < push_pct)
                    queue_op(cdq_pkg::kind_t'($urandom_range(1, 0)), $urandom());
                else
                    queue_op(cdq_pkg::kind_t'($urandom_range(3, 2)), $urandom());
                count--;
            end
        end
    endtask

    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (op_backlog.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    initial
    begin
        send_idle_pct = 27;
        recv_stall_pct = 87;

        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0000_0001);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h7FFF_FFFF);
        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'h0);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h0000_0000);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h8000_0000);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h7FFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h5555_5555);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'hAAAA_AAAA);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h0000_0001);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'hFFFF_FFFE);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h1234_5678);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h8765_4321);
        for (int i = 0; i < 4; i++)
        begin
            queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
            queue_op(cdq_pkg::KIND_POP_REAR, 32'hFFFF_FFFF);
        end
        queue_op(cdq_pkg::KIND_POP_REAR, 32'h0);

        queue_random_ops(RANDOM_OPS / 3);
        wait_for_drain();

        send_idle_pct = 87;
        recv_stall_pct = 27;
        queue_random_ops(RANDOM_OPS / 3);
        wait_for_drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_ops(RANDOM_OPS - 2 * (RANDOM_OPS / 3));
        wait_for_drain();

        repeat (20) @(posedge clk);

        $display("Checked %0d results for %0d operations: %0d done, %0d full, %0d empty.",
                 results_checked, ops_accepted, status_seen[cdq_pkg::STATUS_DONE],
                 status_seen[cdq_pkg::STATUS_FULL], status_seen[cdq_pkg::STATUS_EMPTY]);
        $display("Peak occupancy %0d of %0d across three idle and stall patterns.",
                 peak_occ, DEPTH);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
